@@ hw/rtl/pds_pkg.sv @@
// Shared constants and types for the proper divisor sum block.
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

    localparam int DEFAULT_NUMBER_WIDTH = 32;
    localparam int OUT_SUM_W            = 36;

    typedef struct packed {
        logic [OUT_SUM_W-1:0] divisor_sum;
        logic                 is_abundant;
    } pds_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pds_if.sv @@
// Valid/ready stream interfaces for the operand and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface pds_in_if #(
    parameter int NUMBER_WIDTH = pds_pkg::DEFAULT_NUMBER_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface pds_out_if;
    logic                           valid;
    logic                           ready;
    logic [pds_pkg::OUT_SUM_W-1:0]  divisor_sum;
    logic                           is_abundant;

    modport source (output valid, output divisor_sum, output is_abundant, input ready);
    modport sink   (input valid, input divisor_sum, input is_abundant, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/proper_divisor_sum_top.sv @@
// Top level of the proper divisor sum block: channels and result register.
//
// Takes one positive integer on the operand channel and returns the sum of
// its proper divisors (divisors below the number) and an abundant flag on the
// result channel. Zero and one give a sum of zero.
// Both channels transfer on a rising edge with valid and ready high.
// operand.ready is high only while the sequencer is idle; one number is
// worked on at a time. The work runs through a single shared subtractor:
// first R, the floor square root of the number, then trial divisions by 2
// up to R, each over a padded dividend of W = 2*ceil(NUMBER_WIDTH/2) bits
// at one quotient bit per cycle. Zero and one skip both loops.
// Finished results go to an output register; the next operand is taken while
// a result waits there. If the receiver stalls with a result still held, the
// sequencer holds its next result until the register frees up.
// Reset clears the sequencer to idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module proper_divisor_sum_top #(
    parameter int NUMBER_WIDTH = pds_pkg::DEFAULT_NUMBER_WIDTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pds_in_if.sink      operand,
    pds_out_if.source   result
);
    import pds_pkg::*;

    logic        core_idle;
    logic        core_done;
    logic        take;
    pds_result_t core_result;

    logic        out_valid_reg, out_valid_next;
    pds_result_t out_data_reg;

    assign take = ~out_valid_reg | result.ready;

    pds_core #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (operand.valid & core_idle),
        .number (operand.number),
        .idle   (core_idle),
        .done   (core_done),
        .take   (take),
        .result (core_result)
    );

    assign operand.ready = core_idle;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_done && take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (core_done && take)
            out_data_reg <= core_result;
    end

    assign result.valid       = out_valid_reg;
    assign result.divisor_sum = out_data_reg.divisor_sum;
    assign result.is_abundant = out_data_reg.is_abundant;

endmodule

`default_nettype wire

@@ hw/rtl/pds_core.sv @@
// Sequencer and shared subtract unit: integer square root, trial divisions, summing.
`timescale 1ns / 1ps
`default_nettype none

module pds_core #(
    parameter int NUMBER_WIDTH = pds_pkg::DEFAULT_NUMBER_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [NUMBER_WIDTH-1:0] number,
    output logic                         idle,
    output logic                         done,
    input  wire logic                    take,
    output pds_pkg::pds_result_t         result
);
    import pds_pkg::*;

    localparam int RW    = (NUMBER_WIDTH + 1) / 2;   // root width
    localparam int DQ_W  = 2 * RW;                   // padded dividend width
    localparam int SUB_W = RW + 2;
    localparam int SUM_W = (NUMBER_WIDTH + 4 > OUT_SUM_W + 1) ? NUMBER_WIDTH + 4
                                                              : OUT_SUM_W + 1;
    localparam int CNT_W = $clog2(DQ_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ADDI  = 3'd4;
    localparam logic [2:0] S_ADDQ  = 3'd5;
    localparam logic [2:0] S_ADDR  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [RW-1:0]           root_reg, root_next;
    logic [SUB_W-1:0]        rem_reg, rem_next;
    logic [DQ_W-1:0]         dq_reg, dq_next;
    logic [RW:0]             i_reg, i_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    exact_reg, exact_next;

    logic [SUB_W-1:0]        sub_a, sub_b;
    logic [SUB_W:0]          diff;
    logic                    ge;
    logic [SUB_W-1:0]        rem_step;
    logic [SUM_W-1:0]        addend, sum_add;
    logic                    past_limit;

    // shared compare/subtract: one root digit or one quotient bit per cycle
    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                sub_a = {rem_reg[RW-1:0], dq_reg[DQ_W-1 -: 2]};
                sub_b = {root_reg, 2'b01};
            end
            default:
            begin
                sub_a = {rem_reg[RW:0], dq_reg[DQ_W-1]};
                sub_b = {1'b0, i_reg};
            end
        endcase
    end

    assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge       = ~diff[SUB_W];
    assign rem_step = ge ? diff[SUB_W-1:0] : sub_a;

    always_comb
    begin
        case (state_reg)
            S_ADDI:  addend = SUM_W'(i_reg);
            S_ADDQ:  addend = SUM_W'(dq_reg);
            S_ADDR:  addend = SUM_W'(root_reg);
            default: addend = '0;
        endcase
    end

    assign sum_add = sum_reg + addend;

    // an exact root is left to the final add
    assign past_limit = exact_reg ? (i_reg >= {1'b0, root_reg})
                                  : (i_reg >  {1'b0, root_reg});

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        i_next     = i_reg;
        cnt_next   = cnt_reg;
        exact_next = exact_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next    = number;
                    rem_next  = '0;
                    root_next = '0;
                    dq_next   = DQ_W'(number);
                    cnt_next  = CNT_W'(RW - 1);
                    if (number > NUMBER_WIDTH'(1))
                    begin
                        sum_next   = SUM_W'(1);
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        sum_next   = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_SQRT:
            begin
                dq_next   = {dq_reg[DQ_W-3:0], 2'b00};
                rem_next  = rem_step;
                root_next = {root_reg[RW-2:0], ge};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    exact_next = (rem_step == '0);
                    i_next     = (RW + 1)'(2);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (past_limit)
                    state_next = exact_reg ? S_ADDR : S_DONE;
                else
                begin
                    rem_next   = '0;
                    dq_next    = DQ_W'(n_reg);
                    cnt_next   = CNT_W'(DQ_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_step;
                dq_next  = {dq_reg[DQ_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                        state_next = S_ADDI;
                    else
                    begin
                        i_next     = i_reg + (RW + 1)'(1);
                        state_next = S_CHECK;
                    end
                end
            end
            S_ADDI:
            begin
                sum_next   = sum_add;
                state_next = S_ADDQ;
            end
            S_ADDQ:
            begin
                sum_next   = sum_add;
                i_next     = i_reg + (RW + 1)'(1);
                state_next = S_CHECK;
            end
            S_ADDR:
            begin
                sum_next   = sum_add;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        sum_reg   <= sum_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        i_reg     <= i_next;
        cnt_reg   <= cnt_next;
        exact_reg <= exact_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);

    assign result.divisor_sum = (|sum_reg[SUM_W-1:OUT_SUM_W]) ? '1
                                                              : sum_reg[OUT_SUM_W-1:0];
    assign result.is_abundant = (sum_reg > SUM_W'(n_reg));

endmodule

`default_nettype wire

@@ verif/tb_proper_divisor_sum_top.sv @@
// Testbench for proper_divisor_sum_top: random and directed numbers, scoreboard vs. aliquot sums.
`timescale 1ns / 1ps

module tb_proper_divisor_sum_top;

    import pds_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          NUM_W          = 32;
    localparam int          RANDOM_ITEMS   = 83;
    // long enough for two of the slowest random numbers to finish behind a held result
    localparam int          HOLD_OFF       = 100_000;
    localparam int          HOLD_AT_RESULT = 25;
    localparam int          DRAIN_CYCLES   = 50;
    localparam longint      TIMEOUT_CYCLES = 30_000_000;
    localparam logic [63:0] SUM_CEILING    = (64'd1 << OUT_SUM_W) - 64'd1;

    class aliquot_scoreboard;
        pds_result_t       pending[$];
        logic [NUM_W-1:0]  pending_numbers[$];
        int                errors = 0;

        function pds_result_t predict_sum(logic [NUM_W-1:0] number);
            logic [63:0] n;
            logic [63:0] total;
            logic [63:0] root;
            logic [63:0] probe;
            logic [63:0] trial;
            pds_result_t expected;
            n     = {{(64-NUM_W){1'b0}}, number};
            total = 64'd0;
            root  = 64'd0;
            if (n > 64'd1)
            begin
                total = 64'd1;
                // floor square root, one bit at a time from the top
                for (int b = NUM_W / 2 - 1; b >= 0; b--)
                begin
                    probe = root | (64'd1 << b);
                    if (probe * probe <= n)
                        root = probe;
                end
                for (trial = 64'd2; trial * trial < n; trial++)
                    if (n % trial == 64'd0)
                        total += trial + n / trial;
                if (root * root == n)
                    total += root;
            end
            expected.divisor_sum = (total > SUM_CEILING) ? SUM_CEILING[OUT_SUM_W-1:0]
                                                         : total[OUT_SUM_W-1:0];
            expected.is_abundant = (total > n);
            return expected;
        endfunction

        function void note_number(logic [NUM_W-1:0] number);
            pending.push_back(predict_sum(number));
            pending_numbers.push_back(number);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_SUM_W-1:0] sum, logic abundant);
            pds_result_t      expected;
            logic [NUM_W-1:0] number;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: sum %0d abundant %0b",
                                          sum, abundant));
                return;
            end
            expected = pending.pop_front();
            number   = pending_numbers.pop_front();
            if (sum !== expected.divisor_sum)
                report_mismatch($sformatf("number %0d: divisor_sum %0d, want %0d",
                                          number, sum, expected.divisor_sum));
            if (abundant !== expected.is_abundant)
                report_mismatch($sformatf("number %0d: is_abundant %0b, want %0b",
                                          number, abundant, expected.is_abundant));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pds_in_if #(.NUMBER_WIDTH(NUM_W)) operand ();
    pds_out_if                        result ();

    proper_divisor_sum_top #(.NUMBER_WIDTH(NUM_W)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result)
    );

    aliquot_scoreboard divisor_board = new();

    int send_calm = 0;
    int recv_calm = 0;
    int results_seen = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Wait before the next transfer; now and then a run of back-to-back transfers.
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(4, 12);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Mostly small numbers: trial division cost grows with the square root.
    function automatic logic [NUM_W-1:0] draw_number();
        int unsigned      pick;
        int unsigned      width;
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] factor;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            value = $urandom_range(1, 1023);
            value = value * value;
        end
        else if (pick == 1)
        begin
            // smooth numbers, rich in divisors and often abundant
            value = 1;
            repeat ($urandom_range(1, 14))
            begin
                case ($urandom_range(0, 3))
                    0: factor = 2;
                    1: factor = 3;
                    2: factor = 5;
                    default: factor = 7;
                endcase
                if (value * factor < (1 << 20))
                    value = value * factor;
            end
        end
        else
        begin
            width = $urandom_range(1, 20);
            value = $urandom & ((32'd1 << width) - 32'd1);
        end
        return value;
    endfunction

    // Caller sits at the edge of the previous transfer; valid stays high on zero gap.
    task automatic send_number(input logic [NUM_W-1:0] value);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            operand.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand.valid  <= 1'b1;
        operand.number <= value;
        @(posedge clk);
        while (!operand.ready)
            @(posedge clk);
        divisor_board.note_number(value);
    endtask

    initial
    begin
        logic [NUM_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd28,
                     32'd121, 32'd496, 32'd945, 32'd8128, 32'd65521, 32'd65536,
                     32'd720720, 32'hFFFF_FFFF};
        rst_n          <= 1'b0;
        operand.valid  <= 1'b0;
        operand.number <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
            send_number(directed[k]);
        repeat (RANDOM_ITEMS)
            send_number(draw_number());
        operand.valid <= 1'b0;
        while (divisor_board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (divisor_board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_AT_RESULT)
                stall = HOLD_OFF;
            else
                stall = draw_wait(recv_calm);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            divisor_board.check_result(result.divisor_sum, result.is_abundant);
            results_seen++;
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pds_pkg.sv
hw/rtl/pds_if.sv
hw/rtl/pds_core.sv
hw/rtl/proper_divisor_sum_top.sv
verif/tb_proper_divisor_sum_top.sv
